@@ hdl/ippfc_pkg.sv @@
// shared types and constants for the ip pair flow counter
`timescale 1ns / 1ps

package ippfc_pkg;

    localparam int RIDX_W = 7;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 176;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    // classified word handed from the front end to the table engine
    typedef struct packed {
        logic              action;
        logic              is_ipv4;
        logic [31:0]       src_addr;
        logic [31:0]       dst_addr;
        logic [RIDX_W-1:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic              is_ipv4;
        logic              matched;
        logic              table_full;
        logic [RIDX_W-1:0] entry_index;
        logic [31:0]       pair_count;
        logic              entry_valid;
        logic [31:0]       entry_src;
        logic [31:0]       entry_dst;
        logic [31:0]       ip_total;
        logic [31:0]       packet_total;
    } res_t;

endpackage

@@ hdl/ip_pair_flow_counter.sv @@
// top level of the ip pair flow counter: front end, table engine, output register
`timescale 1ns / 1ps

// Counts packets per IPv4 (source, destination) pair in a table of TABLE_ENTRIES.
// Input words arrive on s_axis: tuser[0] selects packet header (0) or table
// read (1); tdata carries eth_type, src_addr, dst_addr and read_index.
// Every input word gives exactly one result word on m_axis with the pair
// flags, the entry index and contents, and the saturating ip and packet totals.
// The front end queues up to two words, so s_axis keeps accepting while the
// engine works or while a finished result waits in the output register.
// The engine takes one word at a time. It searches the table memory linearly,
// one entry per cycle, for any IPv4 header into a non-empty table, and stops
// at a match or after the last filled entry, so it searches at most
// TABLE_ENTRIES entries; reads, non-IPv4 headers and IPv4 headers into an
// empty table need no search. Results move on through the output register.
// Reset clears the totals and the fill count; entries at or above the fill
// count read as empty, so the memory needs no clearing pass.
// When m_axis_tready is low the result is held, the engine waits with the
// next result, and s_axis stalls once the queue holds two words.

module ip_pair_flow_counter #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // eth_type[15:0], src_addr[47:16], dst_addr[79:48], read_index[86:80]
    input  logic [ippfc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // is_ipv4[0], matched[1], table_full[2], entry_index[9:3],
    // pair_count[41:10], entry_valid[42], entry_src[74:43],
    // entry_dst[106:75], ip_total[138:107], packet_total[170:139]
    output logic [ippfc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic            cmd_valid;
    logic            cmd_ready;
    ippfc_pkg::cmd_t cmd;
    logic            res_valid;
    logic            res_ready;
    ippfc_pkg::res_t res;

    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic [ippfc_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [ippfc_pkg::M_TDATA_W-1:0] m_data_next;

    ippfc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    ippfc_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            m_data_next = {5'd0, res.packet_total, res.ip_total, res.entry_dst,
                           res.entry_src, res.entry_valid, res.pair_count,
                           res.entry_index, res.table_full, res.matched, res.is_ipv4};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;

endmodule

@@ hdl/ippfc_front.sv @@
// front end: unpacks and classifies input words and queues them for the engine
`timescale 1ns / 1ps

module ippfc_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ippfc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [0:0]                     s_axis_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output ippfc_pkg::cmd_t                cmd
);

    localparam int QUEUE_DEPTH = 2;

    ippfc_pkg::cmd_t q_reg [QUEUE_DEPTH];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            push;
    logic            pop;
    ippfc_pkg::cmd_t in_cmd;

    // tdata: eth_type, src_addr, dst_addr, read_index from bit 0 up
    always_comb begin
        in_cmd.action     = s_axis_tuser[0];
        in_cmd.is_ipv4    = (s_axis_tdata[15:0] == ippfc_pkg::ETYPE_IPV4);
        in_cmd.src_addr   = s_axis_tdata[47:16];
        in_cmd.dst_addr   = s_axis_tdata[79:48];
        in_cmd.read_index = s_axis_tdata[86:80];
    end

    assign s_axis_tready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push = s_axis_tvalid && s_axis_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ hdl/ippfc_engine.sv @@
// table engine: pair table memory, linear search, insert, read and totals
`timescale 1ns / 1ps

module ippfc_engine #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  ippfc_pkg::cmd_t cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output ippfc_pkg::res_t res
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int OW = ippfc_pkg::RIDX_W;
    localparam int CMP_W = (FILL_W > OW) ? FILL_W : OW;
    localparam int MEM_W = 96;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // entry layout: count, source, destination from the top bit down
    logic [MEM_W-1:0] mem [TABLE_ENTRIES];
    logic [MEM_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [MEM_W-1:0] wr_data;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [31:0]       ipv4_reg;
    logic [31:0]       ipv4_next;
    logic [31:0]       frames_reg;
    logic [31:0]       frames_next;
    logic [IDX_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  scan_next;
    ippfc_pkg::cmd_t   cmd_reg;
    ippfc_pkg::cmd_t   cmd_next;
    ippfc_pkg::res_t   res_reg;
    ippfc_pkg::res_t   res_next;

    logic        ins_req;
    logic [31:0] ins_src;
    logic [31:0] ins_dst;
    logic        hit;
    logic        in_range;

    assign hit = (rd_data_reg[63:32] == cmd_reg.src_addr)
              && (rd_data_reg[31:0] == cmd_reg.dst_addr);
    assign in_range = (CMP_W'(cmd_reg.read_index) < CMP_W'(fill_reg));

    always_comb begin
        state_next = state_reg;
        fill_next = fill_reg;
        ipv4_next = ipv4_reg;
        frames_next = frames_reg;
        scan_next = scan_reg;
        cmd_next = cmd_reg;
        res_next = res_reg;
        cmd_ready = 1'b0;
        rd_addr = scan_reg + IDX_W'(1);
        wr_en = 1'b0;
        wr_addr = scan_reg;
        wr_data = '0;
        ins_req = 1'b0;
        ins_src = cmd_reg.src_addr;
        ins_dst = cmd_reg.dst_addr;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_ready = 1'b1;
                    cmd_next = cmd;
                    res_next = '0;
                    if (cmd.action == ippfc_pkg::ACT_READ) begin
                        rd_addr = IDX_W'(cmd.read_index);
                        state_next = ST_READ;
                    end else begin
                        frames_next = sat_inc(frames_reg);
                        if (!cmd.is_ipv4) begin
                            state_next = ST_DONE;
                        end else begin
                            ipv4_next = sat_inc(ipv4_reg);
                            res_next.is_ipv4 = 1'b1;
                            res_next.entry_src = cmd.src_addr;
                            res_next.entry_dst = cmd.dst_addr;
                            if (fill_reg == '0) begin
                                ins_req = 1'b1;
                                ins_src = cmd.src_addr;
                                ins_dst = cmd.dst_addr;
                                state_next = ST_DONE;
                            end else begin
                                rd_addr = '0;
                                scan_next = '0;
                                state_next = ST_SCAN;
                            end
                        end
                    end
                end
            end
            ST_SCAN: begin
                // read data belongs to scan_reg, next address already issued
                if (hit) begin
                    wr_en = 1'b1;
                    wr_addr = scan_reg;
                    wr_data = {sat_inc(rd_data_reg[95:64]), rd_data_reg[63:0]};
                    res_next.matched = 1'b1;
                    res_next.entry_index = OW'(scan_reg);
                    res_next.pair_count = sat_inc(rd_data_reg[95:64]);
                    res_next.entry_valid = 1'b1;
                    state_next = ST_DONE;
                end else if (FILL_W'(scan_reg) + FILL_W'(1) == fill_reg) begin
                    ins_req = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            ST_READ: begin
                res_next.entry_index = cmd_reg.read_index;
                if (in_range) begin
                    res_next.pair_count = rd_data_reg[95:64];
                    res_next.entry_valid = 1'b1;
                    res_next.entry_src = rd_data_reg[63:32];
                    res_next.entry_dst = rd_data_reg[31:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // miss: claim the next free entry unless the table is full
        if (ins_req) begin
            if (fill_reg < FILL_W'(TABLE_ENTRIES)) begin
                wr_en = 1'b1;
                wr_addr = IDX_W'(fill_reg);
                wr_data = {32'd1, ins_src, ins_dst};
                fill_next = fill_reg + FILL_W'(1);
                res_next.entry_index = OW'(fill_reg);
                res_next.pair_count = 32'd1;
                res_next.entry_valid = 1'b1;
            end else begin
                res_next.table_full = 1'b1;
            end
        end
    end

    always_comb begin
        res = res_reg;
        res.ip_total = ipv4_reg;
        res.packet_total = frames_reg;
    end

    assign res_valid = (state_reg == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            ipv4_reg <= '0;
            frames_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            ipv4_reg <= ipv4_next;
            frames_reg <= frames_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (fill_reg == $past(fill_reg))
              || (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("fill count moved by more than one");

    a_totals_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ipv4_reg <= frames_reg)
        else $error("ipv4 total above packet total");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (FILL_W'(scan_reg) < fill_reg))
        else $error("search ran past filled entries");
`endif

endmodule

@@ dv/tb_ip_pair_flow_counter.sv @@
// self-checking testbench for the ip pair flow counter with a predicting scoreboard
`timescale 1ns / 1ps

module tb_ip_pair_flow_counter;

    localparam int TABLE_ENTRIES = 128;
    localparam int DIRECTED_WORDS = 20;
    localparam int RANDOM_PER_PHASE = 410;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_NS = 7_000_000;

    typedef logic [ippfc_pkg::RIDX_W-1:0] ridx_t;

    typedef struct {
        logic        action;
        logic [15:0] etype;
        logic [31:0] src;
        logic [31:0] dst;
        ridx_t       ridx;
    } pkt_word_t;

    // own copy of the pair table and totals, one expected result per accepted word
    class flow_ledger;
        logic [31:0]     src_tab [TABLE_ENTRIES];
        logic [31:0]     dst_tab [TABLE_ENTRIES];
        logic [31:0]     cnt_tab [TABLE_ENTRIES];
        bit              used_tab [TABLE_ENTRIES];
        int unsigned     fill;
        logic [31:0]     ipv4_cnt;
        logic [31:0]     frame_cnt;
        ippfc_pkg::res_t due_results [$];
        int              errors;
        int              n_checked;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                src_tab[i] = '0;
                dst_tab[i] = '0;
                cnt_tab[i] = '0;
                used_tab[i] = 1'b0;
            end
            fill = 0;
            ipv4_cnt = '0;
            frame_cnt = '0;
            errors = 0;
            n_checked = 0;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void note_word(pkt_word_t w);
            ippfc_pkg::res_t r;
            bit              hit;
            r = '0;
            hit = 1'b0;
            if (w.action == ippfc_pkg::ACT_READ) begin
                r.entry_index = w.ridx;
                if (int'(w.ridx) < TABLE_ENTRIES) begin
                    r.pair_count = cnt_tab[w.ridx];
                    r.entry_valid = used_tab[w.ridx];
                    r.entry_src = src_tab[w.ridx];
                    r.entry_dst = dst_tab[w.ridx];
                end
            end else begin
                frame_cnt = bump(frame_cnt);
                if (w.etype == ippfc_pkg::ETYPE_IPV4) begin
                    ipv4_cnt = bump(ipv4_cnt);
                    r.is_ipv4 = 1'b1;
                    for (int i = 0; i < TABLE_ENTRIES && !hit; i++) begin
                        if (used_tab[i] && src_tab[i] == w.src && dst_tab[i] == w.dst) begin
                            cnt_tab[i] = bump(cnt_tab[i]);
                            r.matched = 1'b1;
                            r.entry_index = i[ippfc_pkg::RIDX_W-1:0];
                            r.pair_count = cnt_tab[i];
                            r.entry_valid = 1'b1;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        if (fill < TABLE_ENTRIES) begin
                            src_tab[fill] = w.src;
                            dst_tab[fill] = w.dst;
                            cnt_tab[fill] = 32'd1;
                            used_tab[fill] = 1'b1;
                            r.entry_index = fill[ippfc_pkg::RIDX_W-1:0];
                            r.pair_count = 32'd1;
                            r.entry_valid = 1'b1;
                            fill++;
                        end else begin
                            // no room: flagged, nothing written
                            r.table_full = 1'b1;
                        end
                    end
                    r.entry_src = w.src;
                    r.entry_dst = w.dst;
                end
            end
            r.ip_total = ipv4_cnt;
            r.packet_total = frame_cnt;
            due_results.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] e, logic [31:0] g);
            if (g !== e)
                report($sformatf("word %0d %s expected %h got %h", n_checked, name, e, g));
        endtask

        task check_word(logic [ippfc_pkg::M_TDATA_W-1:0] d);
            ippfc_pkg::res_t e;
            if (due_results.size() == 0) begin
                report($sformatf("result word %h with nothing pending", d));
                return;
            end
            e = due_results.pop_front();
            check_field("is_ipv4", e.is_ipv4, d[0]);
            check_field("matched", e.matched, d[1]);
            check_field("table_full", e.table_full, d[2]);
            check_field("entry_index", e.entry_index, d[9:3]);
            check_field("pair_count", e.pair_count, d[41:10]);
            check_field("entry_valid", e.entry_valid, d[42]);
            check_field("entry_src", e.entry_src, d[74:43]);
            check_field("entry_dst", e.entry_dst, d[106:75]);
            check_field("ip_total", e.ip_total, d[138:107]);
            check_field("packet_total", e.packet_total, d[170:139]);
            n_checked++;
        endtask
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [ippfc_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic [0:0]                      s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [ippfc_pkg::M_TDATA_W-1:0] m_axis_tdata;

    flow_ledger  sb;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold;
    logic [63:0] table_pairs [$];

    ip_pair_flow_counter #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random back-pressure, plus a long hold-off when rx_hold is loaded
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    initial begin
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task push_word(pkt_word_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, w.ridx, w.dst, w.src, w.etype};
        s_axis_tuser <= w.action;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        sb.note_word(w);
        @(negedge aclk);
    endtask

    task send_header(logic [15:0] etype, logic [31:0] src, logic [31:0] dst);
        pkt_word_t w;
        w.action = ippfc_pkg::ACT_PACKET;
        w.etype = etype;
        w.src = src;
        w.dst = dst;
        w.ridx = ridx_t'($urandom_range(127));
        if (etype == ippfc_pkg::ETYPE_IPV4 && sb.fill < TABLE_ENTRIES)
            table_pairs.push_back({src, dst});
        push_word(w);
    endtask

    task send_read(ridx_t idx);
        pkt_word_t w;
        w.action = ippfc_pkg::ACT_READ;
        w.etype = 16'($urandom);
        w.src = $urandom;
        w.dst = $urandom;
        w.ridx = idx;
        push_word(w);
    endtask

    task wait_drained();
        while (sb.due_results.size() != 0)
            @(negedge aclk);
    endtask

    task run_random(int n);
        int          k;
        logic [63:0] pair;
        logic [31:0] src;
        logic [31:0] dst;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            src = $urandom;
            dst = $urandom;
            if (k < 15) begin
                if ($urandom_range(1) && sb.fill > 0)
                    send_read(ridx_t'($urandom_range(sb.fill - 1)));
                else
                    send_read(ridx_t'($urandom_range(127)));
            end else if (k < 25) begin
                // non-ipv4 noise, half of it one bit away from the ipv4 type
                if ($urandom_range(1))
                    send_header(ippfc_pkg::ETYPE_IPV4 ^ (16'h1 << $urandom_range(15)),
                                src, dst);
                else
                    send_header(16'($urandom), src, dst);
            end else if (k < 65 && table_pairs.size() > 0) begin
                pair = table_pairs[$urandom_range(table_pairs.size() - 1)];
                send_header(ippfc_pkg::ETYPE_IPV4, pair[63:32], pair[31:0]);
            end else if (k < 80 && table_pairs.size() > 0) begin
                // near miss of a stored pair
                pair = table_pairs[$urandom_range(table_pairs.size() - 1)];
                pair = pair ^ (64'h1 << $urandom_range(63));
                send_header(ippfc_pkg::ETYPE_IPV4, pair[63:32], pair[31:0]);
            end else begin
                send_header(ippfc_pkg::ETYPE_IPV4, src, dst);
            end
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        rx_hold = 0;
        tx_idle_pct = 19;
        rx_idle_pct = 74;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty reads, odd ether types, address extremes, swapped pairs
        send_read(7'd0);
        send_read(7'd127);
        send_header(16'h0000, 32'h0, 32'h0);
        send_header(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_header(16'h0801, 32'h0A00_0001, 32'h0A00_0002);
        send_header(16'h0008, 32'h0A00_0001, 32'h0A00_0002);
        send_header(16'h86DD, 32'hFFFF_FFFF, 32'h0);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'h0, 32'h0);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'h0, 32'h0);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'hFFFF_FFFF, 32'h0);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'h0, 32'hFFFF_FFFF);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'hC0A8_0001, 32'h0808_0808);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'h0808_0808, 32'hC0A8_0001);
        send_header(ippfc_pkg::ETYPE_IPV4, 32'hC0A8_0001, 32'h0808_0808);
        send_read(7'd0);
        send_read(7'd3);
        send_read(7'd6);
        send_read(7'd127);

        // sender pauses until every result is back
        s_axis_tvalid <= 1'b0;
        wait_drained();

        run_random(RANDOM_PER_PHASE);
        tx_idle_pct = 74;
        rx_idle_pct = 19;
        run_random(RANDOM_PER_PHASE);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long receiver hold-off while words keep coming, fills the input queue
        rx_hold = HOLD_CYCLES;
        run_random(RANDOM_PER_PHASE);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (TABLE_ENTRIES + 16) @(negedge aclk);

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
